// ===== src/pwfc_pkg.sv =====
// Package with shared types, constants and conversion functions for the port word codec.
`timescale 1ns / 1ps
package pwfc_pkg;

   localparam int CONSTANT_CODE_DEFAULT = 0;
   localparam int BLOCK_CODE_DEFAULT    = 1;
   localparam logic [28:0] MAG_MAX      = 29'h1FFF_FFFF;

   typedef enum logic {
      OP_DECODE = 1'b0,
      OP_ENCODE = 1'b1
   } op_type;

   typedef enum logic {
      KIND_CONSTANT = 1'b0,
      KIND_BLOCK    = 1'b1
   } kind_type;

   typedef struct packed {
      logic        op;
      logic [31:0] port_word;
      logic        kind_in;
      logic [31:0] value_in;
      logic [15:0] address_in;
   } req_type;

   typedef struct packed {
      logic        kind_out;
      logic [31:0] value_out;
      logic [15:0] address_out;
      logic [31:0] word_out;
   } rsp_type;

   // Sign-magnitude Q16.13 to single precision, round to nearest even.
   function automatic logic [31:0] q_to_single(input logic [29:0] payload);
      logic        sign;
      logic [28:0] mag;
      logic [4:0]  msb;
      logic [28:0] norm;
      logic [24:0] mant;
      logic [4:0]  low;
      logic        guard;
      logic        sticky;
      logic [31:0] res;
      sign = payload[29];
      mag  = payload[28:0];
      msb  = 5'd0;
      for (int i = 0; i < 29; i++) begin
         if (mag[i]) msb = 5'(i);
      end
      norm   = mag << (5'd28 - msb);
      mant   = {1'b0, norm[28:5]};
      low    = norm[4:0];
      guard  = low[4];
      sticky = |low[3:0];
      if (guard && (sticky || mant[0])) mant = mant + 25'd1;
      // The hidden bit and any rounding carry add into the exponent field.
      res = {sign, 31'd0} + ({24'd0, 8'(msb) + 8'd113} << 23) + {7'd0, mant};
      if (mag == 29'd0) res = {sign, 31'd0};
      return res;
   endfunction

   // Single precision to sign-magnitude Q16.13, truncating and saturating.
   function automatic logic [29:0] single_to_q(input logic [31:0] bits);
      logic        sign;
      logic [7:0]  e;
      logic [23:0] full;
      logic [28:0] q;
      logic [7:0]  sh;
      sign = bits[31];
      e    = bits[30:23];
      full = {1'b1, bits[22:0]};
      sh   = 8'd137 - e;
      if (e == 8'd255) begin
         q = MAG_MAX;
      end else if (e == 8'd0) begin
         q = 29'd0;
      end else if (e >= 8'd143) begin
         q = MAG_MAX;
      end else if (e >= 8'd137) begin
         q = 29'({5'd0, full} << (e - 8'd137));
      end else if (sh >= 8'd24) begin
         q = 29'd0;
      end else begin
         q = 29'(full >> sh[4:0]);
      end
      if (bits[30:0] == 31'd0) return 30'd0;
      return {sign, q};
   endfunction

endpackage

// ===== src/pwfc_channel_if.sv =====
// Valid/ready channel interface carrying a payload of a chosen type.
`timescale 1ns / 1ps
interface pwfc_channel_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/pwfc_convert.sv =====
// Combinational decode and encode of one registered request.
`timescale 1ns / 1ps
module pwfc_convert #(
   parameter int CONSTANT_CODE = 0,
   parameter int BLOCK_CODE    = 1
) (
   input  pwfc_pkg::req_type req,
   output pwfc_pkg::rsp_type rsp
);
   import pwfc_pkg::*;
   localparam logic [1:0] CCODE = 2'(CONSTANT_CODE);
   localparam logic [1:0] BCODE = 2'(BLOCK_CODE);

   always_comb begin
      rsp = '0;
      if (req.op == OP_DECODE) begin
         if (req.port_word[1:0] == CCODE) begin
            rsp.value_out = q_to_single(req.port_word[31:2]);
         end else if (req.port_word[1:0] == BCODE) begin
            rsp.kind_out    = KIND_BLOCK;
            rsp.address_out = req.port_word[17:2];
         end
      end else if (req.kind_in == KIND_BLOCK) begin
         rsp.word_out = {14'd0, req.address_in, BCODE};
      end else begin
         rsp.word_out = {single_to_q(req.value_in), CCODE};
      end
   end
endmodule

// ===== src/port_word_float_codec_unit.sv =====
// Top level of the port word codec: input register, converter and result register.
`timescale 1ns / 1ps
// Each request is converted in one pass of logic between an input register and a
// result register, so a new request is accepted every cycle while the output side
// does not stall; its response is captured in the result register. Throughput is
// one request per cycle, set by the single conversion stage; back pressure on the
// response side stalls both registers together.
module port_word_float_codec_unit #(
   parameter int CONSTANT_CODE = pwfc_pkg::CONSTANT_CODE_DEFAULT,
   parameter int BLOCK_CODE    = pwfc_pkg::BLOCK_CODE_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   pwfc_channel_if.sink   req_channel,
   pwfc_channel_if.source rsp_channel
);
   import pwfc_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, conv;
   logic    advance;

   // The pipeline moves when the result register is empty or being drained.
   assign advance           = !out_valid_ff || rsp_channel.ready;
   assign req_channel.ready = advance;
   assign in_valid_in       = advance ? req_channel.valid : in_valid_ff;
   assign out_valid_in      = advance ? in_valid_ff : out_valid_ff;

   pwfc_convert #(.CONSTANT_CODE(CONSTANT_CODE), .BLOCK_CODE(BLOCK_CODE)) u_convert (
      .req(in_data_ff),
      .rsp(conv)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_data_ff  <= req_channel.payload;
         out_data_ff <= conv;
      end
   end

   assign rsp_channel.valid   = out_valid_ff;
   assign rsp_channel.payload = out_data_ff;

`ifndef NO_ASSERTIONS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_channel.ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("response changed under stall");
   a_no_accept_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_channel.ready |-> !req_channel.ready)
      else $error("request accepted while stalled");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance |=> out_valid_ff)
      else $error("request lost in pipeline");
`endif
endmodule
